// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

   localparam int COORD_W   = 24;
   localparam int RAD_W     = 23;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W + 1;
   localparam int L2_W      = SQ_W + 1;
   localparam int RS2_W     = 2 * COORD_W;
   localparam int NZ_W      = 52;
   localparam int ROOT_W    = COORD_W;
   localparam int ROOT_REM_W = L2_W;
   localparam int PROD_W    = DIFF_W + RAD_W;
   localparam int QUO_W     = RAD_W;
   localparam int LANES     = 6;
   localparam int LAT       = 3 + ROOT_W + 1 + QUO_W + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_ZERO = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANAR    = 1'd1;

   localparam logic [NZ_W-1:0] NEAR_ZERO_RESET = NZ_W'(1678);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [RAD_W-1:0] radius_type;

   typedef struct packed {
      logic                          hit;
      logic                          planar;
      logic [2:0][COORD_W-1:0]       a_pos;
      logic [2:0][COORD_W-1:0]       b_pos;
      logic [2:0][DIFF_W-1:0]        dmag;
      logic [2:0]                    dneg;
      logic [RAD_W-1:0]              ra;
      logic [RAD_W-1:0]              rb;
   } side_type;

endpackage

// ===== rtl/ssc_if.sv =====
interface ssc_req_if import ssc_pkg::*; ();
   logic       valid;
   logic       ready;
   coord_type  a_x;
   coord_type  a_y;
   coord_type  a_z;
   radius_type a_radius;
   coord_type  b_x;
   coord_type  b_y;
   coord_type  b_z;
   radius_type b_radius;

   modport source (output valid, a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius,
                 output ready);
endinterface

interface ssc_rsp_if import ssc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      hit;
   coord_type contact_a_x;
   coord_type contact_a_y;
   coord_type contact_a_z;
   coord_type contact_b_x;
   coord_type contact_b_y;
   coord_type contact_b_z;

   modport source (output valid, hit, contact_a_x, contact_a_y, contact_a_z,
                   contact_b_x, contact_b_y, contact_b_z, input ready);
   modport sink (input valid, hit, contact_a_x, contact_a_y, contact_a_z,
                 contact_b_x, contact_b_y, contact_b_z, output ready);
endinterface

// ===== rtl/ssc_sqrt.sv =====
module ssc_sqrt import ssc_pkg::*; (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [RS2_W-1:0]      x_in,
   output logic [ROOT_W-1:0]     root_out
);

   logic [ROOT_REM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]     root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int Bit = ROOT_W - 1 - k;
      logic [ROOT_REM_W-1:0] rem_src;
      logic [ROOT_REM_W-1:0] trial;
      logic [ROOT_REM_W-1:0] rem_in;
      logic [ROOT_W-1:0]     root_src;
      logic [ROOT_W-1:0]     root_in;

      if (k == 0) begin : g_first
         assign rem_src  = ROOT_REM_W'(x_in);
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         trial = (ROOT_REM_W'(root_src) << (Bit + 1)) + (ROOT_REM_W'(1) << (2 * Bit));
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (ROOT_W'(1) << Bit);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root_out = root_ff[ROOT_W-1];

endmodule

// ===== rtl/ssc_div.sv =====
module ssc_div import ssc_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [PROD_W-1:0] num_in,
   input  logic [ROOT_W-1:0] den_in,
   output logic [QUO_W-1:0]  quo_out
);

   logic [PROD_W-1:0] rem_ff [QUO_W];
   logic [ROOT_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int Bit = QUO_W - 1 - k;
      logic [PROD_W-1:0] rem_src;
      logic [ROOT_W-1:0] den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [PROD_W-1:0] trial;
      logic [PROD_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num_in;
         assign den_src = den_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      always_comb begin
         trial = PROD_W'(den_src) << Bit;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            quo_in = quo_src | (QUO_W'(1) << Bit);
         end else begin
            rem_in = rem_src;
            quo_in = quo_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

// ===== rtl/sphere_sphere_contact_top.sv =====
// throughput: one beat per cycle; the whole pipeline holds while rsp is stalled
// stages: difference, squares, sum and compare, 24 root stages, products,
// 23 quotient stages, saturation into the output register
// reset (synchronous, active high) empties the pipeline and restores both csr values
module sphere_sphere_contact_top import ssc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ssc_req_if.sink               req_bus,
   ssc_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [NZ_W-1:0]       csr_wdata
);

   logic [NZ_W-1:0] nz_ff;
   logic            planar_ff;
   logic [LAT-1:0]  vld_ff;
   logic            adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff     <= NEAR_ZERO_RESET;
         planar_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEAR_ZERO: nz_ff     <= csr_wdata;
            CSR_PLANAR:    planar_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign adv           = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
      end
   end

   // stage 1: center difference
   side_type             s1_in;
   side_type             s1_ff;
   logic [COORD_W-1:0]   rs_in;
   logic [COORD_W-1:0]   rs_ff;
   logic [2:0][COORD_W-1:0] a_vec;
   logic [2:0][COORD_W-1:0] b_vec;

   assign a_vec = {req_bus.a_z, req_bus.a_y, req_bus.a_x};
   assign b_vec = {req_bus.b_z, req_bus.b_y, req_bus.b_x};

   always_comb begin
      logic signed [DIFF_W-1:0] d;
      s1_in        = '0;
      s1_in.planar = planar_ff;
      s1_in.a_pos  = a_vec;
      s1_in.b_pos  = b_vec;
      s1_in.ra     = req_bus.a_radius;
      s1_in.rb     = req_bus.b_radius;
      for (int j = 0; j < 3; j++) begin
         d = signed'({b_vec[j][COORD_W-1], b_vec[j]}) - signed'({a_vec[j][COORD_W-1], a_vec[j]});
         if (j == 2 && planar_ff) begin
            d = '0;
         end
         s1_in.dneg[j] = d[DIFF_W-1];
         s1_in.dmag[j] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      end
      rs_in = COORD_W'(req_bus.a_radius) + COORD_W'(req_bus.b_radius);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         rs_ff <= rs_in;
      end
   end

   // stage 2: squares
   side_type          s2_ff;
   logic [SQ_W-1:0]   sq_ff [3];
   logic [RS2_W-1:0]  rs2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff  <= s1_ff;
         rs2_ff <= rs_ff * rs_ff;
         for (int j = 0; j < 3; j++) begin
            sq_ff[j] <= SQ_W'(s1_ff.dmag[j]) * SQ_W'(s1_ff.dmag[j]);
         end
      end
   end

   // stage 3: squared length and range check
   side_type          s3_in;
   side_type          s3_ff;
   logic [L2_W-1:0]   l2;
   logic [RS2_W-1:0]  l2_ff;

   always_comb begin
      l2        = L2_W'(sq_ff[0]) + L2_W'(sq_ff[1]) + L2_W'(sq_ff[2]);
      s3_in     = s2_ff;
      s3_in.hit = (NZ_W'(l2) >= nz_ff) && (l2 <= L2_W'(rs2_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s3_in;
         l2_ff <= l2[RS2_W-1:0];
      end
   end

   // root stages
   logic [ROOT_W-1:0] len;
   side_type          rt_ff [ROOT_W];

   ssc_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .x_in     (l2_ff),
      .root_out (len)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff[0] <= s3_ff;
         for (int k = 1; k < ROOT_W; k++) begin
            rt_ff[k] <= rt_ff[k-1];
         end
      end
   end

   // product stage
   side_type          pr_in;
   side_type          pr_ff;
   logic [ROOT_W-1:0] len_ff;
   logic [PROD_W-1:0] prod_ff [LANES];

   always_comb begin
      pr_in     = rt_ff[ROOT_W-1];
      pr_in.hit = rt_ff[ROOT_W-1].hit && (len != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff  <= pr_in;
         len_ff <= len;
         for (int j = 0; j < 3; j++) begin
            prod_ff[j]     <= rt_ff[ROOT_W-1].dmag[j] * rt_ff[ROOT_W-1].ra;
            prod_ff[j + 3] <= rt_ff[ROOT_W-1].dmag[j] * rt_ff[ROOT_W-1].rb;
         end
      end
   end

   // quotient stages
   logic [QUO_W-1:0] quo [LANES];
   side_type         dv_ff [QUO_W];

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      ssc_div u_div (
         .clock   (clock),
         .adv     (adv),
         .num_in  (prod_ff[j]),
         .den_in  (len_ff),
         .quo_out (quo[j])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= pr_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   // output stage: offset, saturate, mask
   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W+1:0] hi;
      logic signed [COORD_W+1:0] lo;
      hi = (COORD_W+2)'((1 << (COORD_W - 1)) - 1);
      lo = -hi - (COORD_W+2)'(1);
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

   side_type                 fin;
   logic                     hit_in;
   logic [LANES-1:0][COORD_W-1:0] pt_in;
   logic                     hit_ff;
   logic [LANES-1:0][COORD_W-1:0] pt_ff;

   always_comb begin
      logic signed [COORD_W+1:0] off;
      logic signed [COORD_W+1:0] ca;
      logic signed [COORD_W+1:0] cb;
      fin    = dv_ff[QUO_W-1];
      hit_in = fin.hit;
      pt_in  = '0;
      for (int j = 0; j < 3; j++) begin
         off = signed'((COORD_W+2)'(quo[j]));
         if (fin.dneg[j]) begin
            off = -off;
         end
         ca = signed'({{2{fin.a_pos[j][COORD_W-1]}}, fin.a_pos[j]}) + off;
         off = signed'((COORD_W+2)'(quo[j + 3]));
         if (fin.dneg[j]) begin
            off = -off;
         end
         cb = signed'({{2{fin.b_pos[j][COORD_W-1]}}, fin.b_pos[j]}) - off;
         if (fin.hit && !(j == 2 && fin.planar)) begin
            pt_in[j]     = sat_coord(ca);
            pt_in[j + 3] = sat_coord(cb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         pt_ff  <= pt_in;
      end
   end

   assign rsp_bus.valid       = vld_ff[LAT-1];
   assign rsp_bus.hit         = hit_ff;
   assign rsp_bus.contact_a_x = pt_ff[0];
   assign rsp_bus.contact_a_y = pt_ff[1];
   assign rsp_bus.contact_a_z = pt_ff[2];
   assign rsp_bus.contact_b_x = pt_ff[3];
   assign rsp_bus.contact_b_y = pt_ff[4];
   assign rsp_bus.contact_b_z = pt_ff[5];

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |-> pt_ff == '0)
      else $error("miss beat carries nonzero contact");

   a_planar_z: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && planar_ff |-> rsp_bus.contact_a_z == '0 && rsp_bus.contact_b_z == '0)
      else $error("planar beat carries nonzero z");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && $stable(pt_ff) && $stable(hit_ff))
      else $error("pipeline moved during stall");

endmodule
